@@ rtl/core/sorted_array_priority_queue_assert.svh @@
// assertion macros for the sorted array priority queue
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// condition must hold in the same cycle
`define SPQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spq check failed");

// condition must hold in the next cycle
`define SPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spq check failed");

`endif

@@ rtl/core/spq_pkg.sv @@
// types and constants shared by the priority queue cells and top level
package spq_pkg;

   localparam int SPQ_DEPTH   = 16;
   localparam int CAP_W       = 5;
   localparam int COUNT_OUT_W = 5;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] new_priority;
      logic [15:0]        new_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic                   head_valid;
      logic signed [15:0]     head_priority;
      logic [15:0]            head_tag;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic                   is_empty;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] prio;
      logic [15:0]        tag;
   } entry_type;

endpackage

@@ rtl/core/spq_cell.sv @@
// one slot of the sorted row: holds an entry and shifts with its neighbors
module spq_cell
   import spq_pkg::*;
(
   input  logic      clock,
   input  logic      update,
   input  req_type   req,
   input  logic      occupied,
   input  logic      left_ge,
   input  entry_type left_entry,
   input  entry_type right_entry,
   output logic      ge,
   output entry_type entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // free slots count as greater so the insert point lands at the fill line
   assign ge = !occupied || (entry_ff.prio >= req.new_priority);

   always_comb begin
      entry_in = entry_ff;
      if (req.kind == KIND_REMOVE) begin
         entry_in = right_entry;
      end else if (left_ge) begin
         entry_in = left_entry;
      end else if (ge) begin
         entry_in.prio = req.new_priority;
         entry_in.tag  = req.new_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

@@ rtl/core/sorted_array_priority_queue.sv @@
// sorted array priority queue: a row of DEPTH cells kept in ascending priority order
// result: the result word is valid in the cycle after its request word is accepted
// throughput: one word per cycle unless a waiting result is stalled; each cell
// compares against its own entry and takes its neighbor's entry, so all cells update at once
// reset: entry count zero, capacity 16, result channel empty; slot contents stay
// undefined and are never read below the fill line, so no clearing pass is needed
module sorted_array_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH = SPQ_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_word,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

`include "sorted_array_priority_queue_assert.svh"

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CAP_W-1:0] capacity_ff;
   logic [1:0]       status_ff;
   logic [1:0]       status_in;
   logic             rsp_valid_ff;

   logic      req_fire;
   logic      insert_ok;
   logic      remove_ok;
   logic      update;
   logic      ge_row    [DEPTH];
   entry_type entry_row [DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign insert_ok = (CMP_W'(count_ff) < CMP_W'(capacity_ff)) &&
                      (count_ff < CNT_W'(DEPTH));
   assign remove_ok = (count_ff != '0);
   assign update    = req_fire && ((req_word.kind == KIND_INSERT) ? insert_ok : remove_ok);

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic      occ;
         logic      lge;
         entry_type lent;
         entry_type rent;

         assign occ = (count_ff > CNT_W'(i));
         if (i == 0) begin : g_first
            assign lge  = 1'b0;
            assign lent = entry_row[i];
         end else begin : g_mid
            assign lge  = ge_row[i-1];
            assign lent = entry_row[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign rent = entry_row[i];
         end else begin : g_inner
            assign rent = entry_row[i+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .update      (update),
            .req         (req_word),
            .occupied    (occ),
            .left_ge     (lge),
            .left_entry  (lent),
            .right_entry (rent),
            .ge          (ge_row[i]),
            .entry       (entry_row[i])
         );
      end
   endgenerate

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_DONE;
      if (req_word.kind == KIND_INSERT) begin
         if (insert_ok) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            status_in = STATUS_FULL;
         end
      end else begin
         if (remove_ok) begin
            count_in = count_ff - CNT_W'(1);
         end else begin
            status_in = STATUS_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (req_fire) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff <= status_in;
      end
   end

   // state is frozen while a result waits, so the word is read straight from the row
   always_comb begin
      rsp_word.status        = status_ff;
      rsp_word.head_valid    = (count_ff != '0);
      rsp_word.head_priority = (count_ff != '0) ? entry_row[0].prio : 16'sd0;
      rsp_word.head_tag      = (count_ff != '0) ? entry_row[0].tag : 16'd0;
      rsp_word.entry_count   = COUNT_OUT_W'(count_ff);
      rsp_word.is_empty      = (count_ff == '0);
   end

   assign rsp_valid = rsp_valid_ff;

   `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH))
   `SPQ_ASSERT_NOW(a_head_sorted, count_ff >= CNT_W'(2), entry_row[0].prio <= entry_row[1].prio)
   `SPQ_ASSERT_NEXT(a_drop_keeps, req_fire && req_word.kind == KIND_INSERT && !insert_ok, count_ff == $past(count_ff))
   `SPQ_ASSERT_NEXT(a_fire_gives_word, req_fire, rsp_valid && rsp_word.status == $past(status_in))

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the sorted array priority queue
module testbench;
   import spq_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_word = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_word;
   logic             csr_wr_en = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;

   req_type   request_words[$];
   rsp_type   head_reports[$];
   entry_type queue_entries[SPQ_DEPTH];
   int        fill_count = 0;
   int        cap_setting = 16;
   int        sender_idle_pct = 0;
   int        recv_stall_pct = 0;
   int        error_count = 0;
   int        checked_count = 0;

   sorted_array_priority_queue u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // applies one request word to the local copy of the queue and returns the head report
   function automatic rsp_type step_sorted_queue(req_type r);
      int      limit;
      int      pos;
      rsp_type res;
      limit = (cap_setting < SPQ_DEPTH) ? cap_setting : SPQ_DEPTH;
      res = '0;
      res.status = STATUS_DONE;
      if (r.kind == KIND_INSERT) begin
         if (fill_count < limit) begin
            pos = 0;
            // new entry goes in front of equal priorities
            while (pos < fill_count &&
                   $signed(queue_entries[pos].prio) < $signed(r.new_priority))
               pos++;
            for (int i = fill_count; i > pos; i--)
               queue_entries[i] = queue_entries[i-1];
            queue_entries[pos].prio = r.new_priority;
            queue_entries[pos].tag = r.new_tag;
            fill_count++;
         end else begin
            res.status = STATUS_FULL;
         end
      end else if (fill_count > 0) begin
         for (int i = 1; i < fill_count; i++)
            queue_entries[i-1] = queue_entries[i];
         fill_count--;
      end else begin
         res.status = STATUS_EMPTY;
      end
      if (fill_count > 0) begin
         res.head_valid = 1'b1;
         res.head_priority = queue_entries[0].prio;
         res.head_tag = queue_entries[0].tag;
      end
      res.entry_count = COUNT_OUT_W'(fill_count);
      res.is_empty = (fill_count == 0);
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (error_count < 100)
         $display("%0t: result %0d %s: got %h want %h", $time, checked_count, what, got, want);
      error_count++;
   endtask

   task automatic add_word(logic kind, int prio, int tag);
      req_type w;
      w.kind = kind;
      w.new_priority = 16'(prio);
      w.new_tag = 16'(tag);
      request_words.push_back(w);
   endtask

   // returns once no word is pending, in flight or owed
   task automatic wait_idle();
      do @(negedge clock);
      while (request_words.size() != 0 || req_valid || head_reports.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_capacity(int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= CAP_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_setting = value & 31;
   endtask

   // driver: predicts each accepted word, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            head_reports.push_back(step_sorted_queue(req_word));
         if (!req_valid || !req_stall) begin
            if (request_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_word <= request_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each accepted result word against the oldest prediction
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (head_reports.size() == 0) begin
               report_mismatch("unexpected word", 32'(rsp_word), '0);
            end else begin
               want = head_reports.pop_front();
               if (rsp_word.status != want.status)
                  report_mismatch("status", 32'(rsp_word.status), 32'(want.status));
               if (rsp_word.head_valid != want.head_valid)
                  report_mismatch("head_valid", 32'(rsp_word.head_valid), 32'(want.head_valid));
               if (rsp_word.head_priority != want.head_priority)
                  report_mismatch("head_priority", 32'(rsp_word.head_priority),
                                  32'(want.head_priority));
               if (rsp_word.head_tag != want.head_tag)
                  report_mismatch("head_tag", 32'(rsp_word.head_tag), 32'(want.head_tag));
               if (rsp_word.entry_count != want.entry_count)
                  report_mismatch("entry_count", 32'(rsp_word.entry_count),
                                  32'(want.entry_count));
               if (rsp_word.is_empty != want.is_empty)
                  report_mismatch("is_empty", 32'(rsp_word.is_empty), 32'(want.is_empty));
            end
            checked_count++;
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   initial begin : stimulus
      int   cap_plan[8] = '{31, 1, 16, 4, 2, 17, 9, 0};
      int   sender_plan[4] = '{0, 76, 0, 16};
      int   stall_plan[4] = '{0, 0, 76, 16};
      bit   filling;
      int   prio;
      logic kind;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: empty removal, extremes, equal priorities
      add_word(KIND_REMOVE, -1, 'hffff);
      add_word(KIND_INSERT, 32767, 'hffff);
      add_word(KIND_INSERT, -32768, 'h0000);
      add_word(KIND_INSERT, 0, 'h1234);
      add_word(KIND_INSERT, 0, 'h5678);
      add_word(KIND_INSERT, -1, 'haaaa);
      add_word(KIND_REMOVE, -1, 'hffff);
      add_word(KIND_REMOVE, 0, 0);
      wait_idle();

      // capacity dropped below the held count: inserts refused until drained
      write_capacity(2);
      add_word(KIND_INSERT, 5, 'h0001);
      add_word(KIND_REMOVE, 0, 0);
      add_word(KIND_REMOVE, 0, 0);
      add_word(KIND_INSERT, 7, 'h0002);
      add_word(KIND_REMOVE, 0, 0);
      add_word(KIND_INSERT, 3, 'h0003);
      wait_idle();

      // capacity zero: nothing can be inserted
      write_capacity(0);
      add_word(KIND_INSERT, 1, 'h0004);
      add_word(KIND_REMOVE, 0, 0);
      add_word(KIND_REMOVE, 0, 0);
      add_word(KIND_REMOVE, 0, 0);
      add_word(KIND_INSERT, -5, 'h0005);
      wait_idle();

      cap_plan[7] = $urandom_range(0, 31);
      for (int p = 0; p < 8; p++) begin
         write_capacity(cap_plan[p]);
         sender_idle_pct = sender_plan[p % 4];
         recv_stall_pct = stall_plan[p % 4];
         filling = 1'b1;
         for (int n = 0; n < 250; n++) begin
            // long fill and drain runs so that full and empty are both reached
            if ($urandom_range(0, 11) == 0)
               filling = !filling;
            if (filling)
               kind = ($urandom_range(0, 99) < 80) ? KIND_INSERT : KIND_REMOVE;
            else
               kind = ($urandom_range(0, 99) < 80) ? KIND_REMOVE : KIND_INSERT;
            case ($urandom_range(0, 3))
               0: begin
                  case ($urandom_range(0, 3))
                     0: prio = -32768;
                     1: prio = 32767;
                     2: prio = 0;
                     default: prio = -1;
                  endcase
               end
               1: begin
                  prio = $urandom_range(0, 8);
                  prio = prio - 4;
               end
               default: prio = $urandom;
            endcase
            add_word(kind, prio, $urandom);
         end
         wait_idle();
      end

      sender_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("[sorted_array_priority_queue] OK");
      else
         $display("[sorted_array_priority_queue] ERROR");
      $finish;
   end

   initial begin
      #5000000;
      $display("[sorted_array_priority_queue] ERROR");
      $finish;
   end

endmodule
